>>> hw/rtl/pet_pkg.sv
package pet_pkg;

   localparam int MAX_VERTICES = 6;
   localparam int COORD_BITS   = 16;

   localparam int IDX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int VTX_W    = 2 * COORD_BITS;
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int DET_W    = PROD_W + 1;
   localparam int OPCODE_W = 2;
   localparam int STEP_W   = 3;
   localparam int XOP_W    = 2;

   // Item opcodes.
   localparam logic [OPCODE_W-1:0] OP_CLEAR         = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND_FIRST  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_APPEND_SECOND = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TEST          = 2'd3;

   // Cross products issued to the shared unit.
   localparam logic [XOP_W-1:0] XOP_SD  = 2'd0;
   localparam logic [XOP_W-1:0] XOP_SC  = 2'd1;
   localparam logic [XOP_W-1:0] XOP_DEN = 2'd2;
   localparam logic [XOP_W-1:0] XOP_NUM = 2'd3;

   // Steps of one edge pair. The cross unit has two register stages, so the SD, SC,
   // DEN and NUM products issued in steps SD to NUM are seen in steps DEN to EVAL.
   localparam logic [STEP_W-1:0] STEP_READ = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DIFF = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SD   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SC   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DEN  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_NUM  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_WAIT = 3'd6;
   localparam logic [STEP_W-1:0] STEP_EVAL = 3'd7;

   typedef struct packed {
      logic              we_first;
      logic              we_second;
      logic [IDX_W-1:0]  waddr;
      logic [IDX_W-1:0]  rd_first_a;
      logic [IDX_W-1:0]  rd_first_b;
      logic [IDX_W-1:0]  rd_second_a;
      logic [IDX_W-1:0]  rd_second_b;
      logic              load_diff;
      logic [XOP_W-1:0]  xop;
      logic              cap_sd;
      logic              cap_sc;
      logic              cap_den;
   } pet_cmd_type;

   typedef struct packed {
      logic pair_hit;
   } pet_status_type;

endpackage

>>> hw/rtl/pet_ram.sv
module pet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> hw/rtl/pet_datapath.sv
module pet_datapath
   import pet_pkg::*;
(
   input  logic                         clock,
   input  pet_cmd_type                  cmd,
   input  logic signed [COORD_BITS-1:0] vertex_x,
   input  logic signed [COORD_BITS-1:0] vertex_y,
   output pet_status_type               status
);

   logic [VTX_W-1:0] wdata;
   logic [VTX_W-1:0] fa_data;
   logic [VTX_W-1:0] fb_data;
   logic [VTX_W-1:0] sa_data;
   logic [VTX_W-1:0] sb_data;

   logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;

   logic signed [DIFF_W-1:0] abx_ff, aby_ff, cdx_ff, cdy_ff;
   logic signed [DIFF_W-1:0] dax_ff, day_ff, cax_ff, cay_ff;
   logic signed [DIFF_W-1:0] abx_in, aby_in, cdx_in, cdy_in;
   logic signed [DIFF_W-1:0] dax_in, day_in, cax_in, cay_in;

   logic signed [DIFF_W-1:0] mul_a, mul_b, mul_c, mul_d;
   logic signed [PROD_W-1:0] ext_a, ext_b, ext_c, ext_d;
   logic signed [PROD_W-1:0] prod1_ff, prod2_ff, prod1_in, prod2_in;
   logic signed [DET_W-1:0]  det_ff, det_in;

   logic                    sd_neg_ff, sd_nz_ff, sc_neg_ff, sc_nz_ff;
   logic signed [DET_W-1:0] den_ff;

   logic side_ok;
   logic den_zero;
   logic num_zero;
   logic den_neg;
   logic num_neg;
   logic in_range;

   assign wdata = {vertex_y, vertex_x};

   pet_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_first_ram (
      .clock   (clock),
      .we      (cmd.we_first),
      .waddr   (cmd.waddr),
      .wdata   (wdata),
      .raddr_a (cmd.rd_first_a),
      .raddr_b (cmd.rd_first_b),
      .rdata_a (fa_data),
      .rdata_b (fb_data)
   );

   pet_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_second_ram (
      .clock   (clock),
      .we      (cmd.we_second),
      .waddr   (cmd.waddr),
      .wdata   (wdata),
      .raddr_a (cmd.rd_second_a),
      .raddr_b (cmd.rd_second_b),
      .rdata_a (sa_data),
      .rdata_b (sb_data)
   );

   assign ax = fa_data[COORD_BITS-1:0];
   assign ay = fa_data[VTX_W-1:COORD_BITS];
   assign bx = fb_data[COORD_BITS-1:0];
   assign by = fb_data[VTX_W-1:COORD_BITS];
   assign cx = sa_data[COORD_BITS-1:0];
   assign cy = sa_data[VTX_W-1:COORD_BITS];
   assign dx = sb_data[COORD_BITS-1:0];
   assign dy = sb_data[VTX_W-1:COORD_BITS];

   assign abx_in = DIFF_W'(bx) - DIFF_W'(ax);
   assign aby_in = DIFF_W'(by) - DIFF_W'(ay);
   assign cdx_in = DIFF_W'(dx) - DIFF_W'(cx);
   assign cdy_in = DIFF_W'(dy) - DIFF_W'(cy);
   assign dax_in = DIFF_W'(dx) - DIFF_W'(ax);
   assign day_in = DIFF_W'(dy) - DIFF_W'(ay);
   assign cax_in = DIFF_W'(cx) - DIFF_W'(ax);
   assign cay_in = DIFF_W'(cy) - DIFF_W'(ay);

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         abx_ff <= abx_in;
         aby_ff <= aby_in;
         cdx_ff <= cdx_in;
         cdy_ff <= cdy_in;
         dax_ff <= dax_in;
         day_ff <= day_in;
         cax_ff <= cax_in;
         cay_ff <= cay_in;
      end
   end

   // Operand selection for the shared cross unit, which forms a*b - c*d.
   // The numerator is cdx*(ay-cy) - cdy*(ax-cx), rewritten as
   // cdy*(cx-ax) - cdx*(cy-ay).
   always_comb begin
      case (cmd.xop)
         XOP_SD: begin
            mul_a = abx_ff;
            mul_b = day_ff;
            mul_c = aby_ff;
            mul_d = dax_ff;
         end
         XOP_SC: begin
            mul_a = abx_ff;
            mul_b = cay_ff;
            mul_c = aby_ff;
            mul_d = cax_ff;
         end
         XOP_DEN: begin
            mul_a = abx_ff;
            mul_b = cdy_ff;
            mul_c = aby_ff;
            mul_d = cdx_ff;
         end
         XOP_NUM: begin
            mul_a = cdy_ff;
            mul_b = cax_ff;
            mul_c = cdx_ff;
            mul_d = cay_ff;
         end
         default: begin
            mul_a = abx_ff;
            mul_b = day_ff;
            mul_c = aby_ff;
            mul_d = dax_ff;
         end
      endcase
   end

   assign ext_a    = PROD_W'(mul_a);
   assign ext_b    = PROD_W'(mul_b);
   assign ext_c    = PROD_W'(mul_c);
   assign ext_d    = PROD_W'(mul_d);
   assign prod1_in = ext_a * ext_b;
   assign prod2_in = ext_c * ext_d;
   assign det_in   = DET_W'(prod1_ff) - DET_W'(prod2_ff);

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      det_ff   <= det_in;
      if (cmd.cap_sd) begin
         sd_neg_ff <= det_ff[DET_W-1];
         sd_nz_ff  <= (det_ff != '0);
      end
      if (cmd.cap_sc) begin
         sc_neg_ff <= det_ff[DET_W-1];
         sc_nz_ff  <= (det_ff != '0);
      end
      if (cmd.cap_den) begin
         den_ff <= det_ff;
      end
   end

   // In the last step of a pair the cross unit holds the numerator. The
   // parameter lies in [0,1] when the numerator is zero, or has the sign of
   // the denominator and does not exceed it in magnitude.
   assign side_ok  = sd_nz_ff & sc_nz_ff & (sd_neg_ff ^ sc_neg_ff);
   assign den_zero = (den_ff == '0);
   assign num_zero = (det_ff == '0);
   assign den_neg  = den_ff[DET_W-1];
   assign num_neg  = det_ff[DET_W-1];
   assign in_range = num_zero
                   | ((num_neg == den_neg) & (den_neg ? (det_ff >= den_ff)
                                                      : (det_ff <= den_ff)));

   assign status.pair_hit = side_ok & (den_zero | in_range);

endmodule

>>> hw/rtl/pet_ctrl.sv
module pet_ctrl
   import pet_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic                rsp_overflow,
   output pet_cmd_type         cmd,
   input  pet_status_type      status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic             dropped_ff, dropped_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic             rsp_overflow_ff, rsp_overflow_in;

   logic             accept;
   logic             i_last;
   logic             j_last;
   logic [IDX_W-1:0] i_next;
   logic [IDX_W-1:0] j_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // The closing edge of each polygon runs from its last vertex to vertex 0.
   assign i_last = (CNT_W'(i_ff) + CNT_W'(1)) >= first_count_ff;
   assign j_last = (CNT_W'(j_ff) + CNT_W'(1)) >= second_count_ff;
   assign i_next = i_last ? '0 : i_ff + IDX_W'(1);
   assign j_next = j_last ? '0 : j_ff + IDX_W'(1);

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      hit_in          = hit_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_hit_in      = rsp_hit_ff;
      rsp_overflow_in = rsp_overflow_ff;

      cmd.we_first    = 1'b0;
      cmd.we_second   = 1'b0;
      cmd.waddr       = '0;
      cmd.rd_first_a  = i_ff;
      cmd.rd_first_b  = i_next;
      cmd.rd_second_a = j_ff;
      cmd.rd_second_b = j_next;
      cmd.load_diff   = 1'b0;
      cmd.xop         = XOP_SD;
      cmd.cap_sd      = 1'b0;
      cmd.cap_sc      = 1'b0;
      cmd.cap_den     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_CLEAR: begin
                     first_count_in  = '0;
                     second_count_in = '0;
                     dropped_in      = 1'b0;
                  end
                  OP_APPEND_FIRST: begin
                     if (first_count_ff < CNT_W'(MAX_VERTICES)) begin
                        cmd.we_first   = 1'b1;
                        cmd.waddr      = first_count_ff[IDX_W-1:0];
                        first_count_in = first_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_APPEND_SECOND: begin
                     if (second_count_ff < CNT_W'(MAX_VERTICES)) begin
                        cmd.we_second   = 1'b1;
                        cmd.waddr       = second_count_ff[IDX_W-1:0];
                        second_count_in = second_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_TEST: begin
                     hit_in  = 1'b0;
                     i_in    = '0;
                     j_in    = '0;
                     step_in = STEP_READ;
                     if ((first_count_ff == '0) || (second_count_ff == '0)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               STEP_DIFF: cmd.load_diff = 1'b1;
               STEP_SD:   cmd.xop = XOP_SD;
               STEP_SC:   cmd.xop = XOP_SC;
               STEP_DEN: begin
                  cmd.xop    = XOP_DEN;
                  cmd.cap_sd = 1'b1;
               end
               STEP_NUM: begin
                  cmd.xop    = XOP_NUM;
                  cmd.cap_sc = 1'b1;
               end
               STEP_WAIT: cmd.cap_den = 1'b1;
               STEP_EVAL: begin
                  step_in = STEP_READ;
                  if (status.pair_hit) begin
                     hit_in   = 1'b1;
                     state_in = ST_DONE;
                  end else if (j_last) begin
                     j_in = '0;
                     if (i_last) begin
                        state_in = ST_DONE;
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DONE: begin
            // Wait here while an earlier result is still held by the receiver.
            if (~rsp_valid_ff | ~rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_overflow_in = dropped_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= STEP_READ;
         i_ff            <= '0;
         j_ff            <= '0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         hit_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         hit_ff          <= hit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff      <= rsp_hit_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

>>> hw/rtl/polygon_edge_intersection_test.sv
// Polygon edge intersection test.
// Input items arrive on req_valid/req_stall with an opcode and a vertex.
// A clear or an append returns no result and leaves req_stall low. A test item
// walks every pair of edges of the two stored polygons and returns one
// result on rsp_valid/rsp_stall: hit, and overflow (a vertex was dropped
// since the last clear).
// Each edge pair passes through a registered read of both vertex RAMs,
// a difference stage, and four cross products through one shared unit of
// two multipliers with two register stages. A test therefore walks the
// n1 * n2 edge pairs in turn (36 for two full polygons of 6 vertices),
// fewer when a hit ends the walk early; with an empty polygon it walks none.
// The block works on one item at a time: req_stall is high while a test
// runs. The result sits in an output register, so the next item is
// accepted while the receiver stalls; a following test waits for that
// register before it delivers its own result.
// Synchronous reset empties both polygons and clears the overflow flag
// and any pending result. Vertex RAM contents are not cleared.
module polygon_edge_intersection_test
   import pet_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OPCODE_W-1:0]          req_opcode,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic                         rsp_overflow
);

   pet_cmd_type    cmd;
   pet_status_type status;

   pet_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_overflow (rsp_overflow),
      .cmd          (cmd),
      .status       (status)
   );

   pet_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .vertex_x (req_vertex_x),
      .vertex_y (req_vertex_y),
      .status   (status)
   );

endmodule

>>> tb/sv/tb_polygon_edge_intersection_test.sv
module tb_polygon_edge_intersection_test
   import pet_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 3_000_000;
   // Settle time covers a full test of two 6-vertex polygons.
   localparam int SETTLE_CYCLES = 400;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam int FIRST_POLY  = 0;
   localparam int SECOND_POLY = 1;

   localparam int SPREAD_GRID    = 0;
   localparam int SPREAD_MID     = 1;
   localparam int SPREAD_FULL    = 2;
   localparam int SPREAD_EXTREME = 3;

   typedef logic signed [127:0] cross_type;

   typedef struct {
      bit hit;
      bit overflow;
   } verdict_type;

   logic                         clock        = 1'b0;
   logic                         reset        = 1'b1;
   logic                         req_valid    = 1'b0;
   logic                         req_stall;
   logic [OPCODE_W-1:0]          req_opcode   = OP_CLEAR;
   logic signed [COORD_BITS-1:0] req_vertex_x = '0;
   logic signed [COORD_BITS-1:0] req_vertex_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall    = 1'b0;
   logic                         rsp_hit;
   logic                         rsp_overflow;

   // Shadow copy of the two polygons and the drop flag.
   logic signed [COORD_BITS-1:0] poly_x [2][MAX_VERTICES];
   logic signed [COORD_BITS-1:0] poly_y [2][MAX_VERTICES];
   int                           poly_len [2] = '{0, 0};
   bit                           poly_dropped = 1'b0;

   verdict_type expected_verdicts[$];
   int       mismatch_count = 0;
   int       cycle_count    = 0;
   int       items_sent     = 0;
   int       idle_pct       = 0;
   int       stall_pct      = 0;
   int       stall_run      = 0;

   polygon_edge_intersection_test u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_vertex_x (req_vertex_x),
      .req_vertex_y (req_vertex_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap(int pct);
      if (int'($urandom_range(99)) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(int spread);
      int v;
      case (spread)
         SPREAD_GRID: v = int'($urandom_range(16)) - 8;
         SPREAD_MID:  v = int'($urandom_range(2000)) - 1000;
         SPREAD_FULL: v = int'($urandom);
         default: begin
            case ($urandom_range(3))
               0: v = int'(COORD_MIN);
               1: v = int'(COORD_MAX);
               2: v = 0;
               default: v = -1;
            endcase
         end
      endcase
      return v[COORD_BITS-1:0];
   endfunction

   // Exact segment test: C and D strictly on opposite sides of line AB, and
   // the crossing parameter along AB within [0,1] checked without division.
   function automatic bit edges_cross(cross_type ax, ay, bx, by, cx, cy, dx, dy);
      cross_type abx, aby, cdx, cdy, side_d, side_c, den, num, mag_num, mag_den;
      abx = bx - ax;
      aby = by - ay;
      cdx = dx - cx;
      cdy = dy - cy;
      side_d = abx * (dy - ay) - aby * (dx - ax);
      side_c = abx * (cy - ay) - aby * (cx - ax);
      if (side_d == 0 || side_c == 0 || ((side_d < 0) == (side_c < 0))) return 1'b0;
      den = abx * cdy - aby * cdx;
      if (den == 0) return 1'b1;
      num = cdx * (ay - cy) - cdy * (ax - cx);
      if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
      mag_num = (num < 0) ? -num : num;
      mag_den = (den < 0) ? -den : den;
      return mag_num <= mag_den;
   endfunction

   function automatic bit polygons_cross();
      int ib, jb;
      for (int i = 0; i < poly_len[FIRST_POLY]; i++) begin
         ib = (i + 1 >= poly_len[FIRST_POLY]) ? 0 : i + 1;
         for (int j = 0; j < poly_len[SECOND_POLY]; j++) begin
            jb = (j + 1 >= poly_len[SECOND_POLY]) ? 0 : j + 1;
            if (edges_cross(poly_x[FIRST_POLY][i], poly_y[FIRST_POLY][i],
                            poly_x[FIRST_POLY][ib], poly_y[FIRST_POLY][ib],
                            poly_x[SECOND_POLY][j], poly_y[SECOND_POLY][j],
                            poly_x[SECOND_POLY][jb], poly_y[SECOND_POLY][jb]))
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_item(logic [OPCODE_W-1:0] op,
                                        logic signed [COORD_BITS-1:0] x, y);
      int       p;
      verdict_type v;
      case (op)
         OP_CLEAR: begin
            poly_len[FIRST_POLY]  = 0;
            poly_len[SECOND_POLY] = 0;
            poly_dropped          = 1'b0;
         end
         OP_APPEND_FIRST, OP_APPEND_SECOND: begin
            p = (op == OP_APPEND_FIRST) ? FIRST_POLY : SECOND_POLY;
            if (poly_len[p] < MAX_VERTICES) begin
               poly_x[p][poly_len[p]] = x;
               poly_y[p][poly_len[p]] = y;
               poly_len[p]++;
            end else begin
               poly_dropped = 1'b1;
            end
         end
         default: begin
            v.hit      = polygons_cross();
            v.overflow = poly_dropped;
            expected_verdicts.push_back(v);
         end
      endcase
   endfunction

   // Returns in the time step of the edge that accepted the item; valid
   // stays high so that a back-to-back item needs no second assignment.
   task automatic send_item(logic [OPCODE_W-1:0] op, logic signed [COORD_BITS-1:0] x, y);
      int gap;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_vertex_x <= x;
      req_vertex_y <= y;
      do @(posedge clock); while (req_stall);
      predict_item(op, x, y);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_run = pick_gap(stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result: hit %0b overflow %0b", rsp_hit, rsp_overflow);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_empty_polygon();
      send_item(OP_TEST, 0, 0);
   endtask

   // A one-vertex polygon has a single zero-length edge, which never hits.
   task automatic test_single_vertex();
      send_item(OP_CLEAR, 0, 0);
      send_item(OP_APPEND_FIRST, 0, 0);
      send_item(OP_APPEND_SECOND, -5, -5);
      send_item(OP_APPEND_SECOND, 5, 5);
      send_item(OP_TEST, 0, 0);
   endtask

   task automatic test_parallel_edges();
      send_item(OP_CLEAR, -1, -1);
      send_item(OP_APPEND_FIRST, 0, 0);
      send_item(OP_APPEND_FIRST, 10, 0);
      send_item(OP_APPEND_SECOND, 0, 5);
      send_item(OP_APPEND_SECOND, 10, 5);
      send_item(OP_TEST, 0, 0);
      // Closing the second polygon into a triangle makes it cross the first.
      send_item(OP_APPEND_SECOND, 5, -5);
      send_item(OP_TEST, 0, 0);
   endtask

   task automatic test_extreme_coords();
      send_item(OP_CLEAR, COORD_MAX, COORD_MIN);
      send_item(OP_APPEND_FIRST, COORD_MIN, COORD_MIN);
      send_item(OP_APPEND_FIRST, COORD_MAX, COORD_MAX);
      send_item(OP_APPEND_SECOND, COORD_MIN, COORD_MAX);
      send_item(OP_APPEND_SECOND, COORD_MAX, COORD_MIN);
      send_item(OP_TEST, COORD_MIN, COORD_MAX);
   endtask

   // Fills the second polygon past capacity so that one vertex is dropped.
   task automatic test_vertex_overflow();
      repeat (MAX_VERTICES - 1)
         send_item(OP_APPEND_SECOND, pick_coord(SPREAD_EXTREME), pick_coord(SPREAD_EXTREME));
      send_item(OP_TEST, -1, -1);
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 0;
      if (r <= 2) return $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 2);
      return $urandom_range(1, MAX_VERTICES);
   endfunction

   // Mostly well-formed shapes (clear, load both polygons, test) with random
   // content; a few shapes skip the clear, grow after a test, or are noise.
   task automatic test_random_polygons();
      int                  start, shapes, spread, n_first, n_second;
      bit                  interleave;
      logic [OPCODE_W-1:0] op;
      start  = items_sent;
      shapes = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         idle_pct  = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
         stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 60);
         spread    = $urandom_range(SPREAD_EXTREME);
         shapes++;
         if ($urandom_range(15) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               op = OPCODE_W'($urandom_range(OP_TEST));
               send_item(op, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
            end
         end else begin
            if ($urandom_range(9) != 0)
               send_item(OP_CLEAR, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
            n_first    = pick_count();
            n_second   = pick_count();
            interleave = ($urandom_range(3) == 0);
            while (n_first + n_second > 0) begin
               if (n_second == 0 || (n_first > 0 && (!interleave || $urandom_range(1) == 0)))
               begin
                  send_item(OP_APPEND_FIRST, pick_coord(spread), pick_coord(spread));
                  n_first--;
               end else begin
                  send_item(OP_APPEND_SECOND, pick_coord(spread), pick_coord(spread));
                  n_second--;
               end
            end
            send_item(OP_TEST, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
            if ($urandom_range(3) == 0) begin
               op = ($urandom_range(1) == 0) ? OP_APPEND_FIRST : OP_APPEND_SECOND;
               send_item(op, pick_coord(spread), pick_coord(spread));
               send_item(OP_TEST, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
            end
         end
         if (shapes % 40 == 0) drain_results();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_polygon();
      test_single_vertex();
      test_parallel_edges();
      test_extreme_coords();
      test_vertex_overflow();
      drain_results();
      test_random_polygons();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/pet_pkg.sv
hw/rtl/pet_ram.sv
hw/rtl/pet_datapath.sv
hw/rtl/pet_ctrl.sv
hw/rtl/polygon_edge_intersection_test.sv
tb/sv/tb_polygon_edge_intersection_test.sv
